>>> design/rpfs_pkg.sv
// ----------------------------------------------------------------------------
// rpfs_pkg
// Shared types and constants of the RGB palette fade sequencer.
// ----------------------------------------------------------------------------
package rpfs_pkg;

  // Field and register widths.
  localparam int ChanW   = 8;
  localparam int ColorW  = 3 * ChanW;
  localparam int StepW   = 16;
  localparam int QuotW   = ChanW + StepW;
  localparam int DivCntW = $clog2(QuotW);

  // Palette geometry. PaletteSize entries of the ring are in use.
  localparam int NumColors   = 7;
  localparam int PaletteSize = 7;
  localparam int PosW        = 3;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = ColorW;
  localparam logic [CfgIdxW-1:0] RegFadeSteps = CfgIdxW'(NumColors);

  localparam logic [StepW-1:0] FadeStepsRst = StepW'(64);

  typedef logic [ColorW-1:0] color_t;

  localparam color_t ColorRst [NumColors] = '{
    24'h100000, 24'h001000, 24'h000010, 24'h101000,
    24'h100010, 24'h001010, 24'h101010
  };

  // Channel codes, used as the index of the channel being computed.
  typedef logic [1:0] chan_t;
  localparam chan_t ChRed   = 2'd0;
  localparam chan_t ChGreen = 2'd1;
  localparam chan_t ChBlue  = 2'd2;

  localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};

endpackage

>>> design/rpfs_if.sv
// ----------------------------------------------------------------------------
// rpfs_in_if / rpfs_out_if
// Valid/ready channels for update ticks and interpolated colors.
// ----------------------------------------------------------------------------
interface rpfs_in_if;
  logic valid;
  logic ready;
  logic link_idle;

  modport source (output valid, output link_idle, input ready);
  modport sink   (input valid, input link_idle, output ready);
endinterface

interface rpfs_out_if;
  logic                      valid;
  logic                      ready;
  logic [rpfs_pkg::ChanW-1:0] red;
  logic [rpfs_pkg::ChanW-1:0] green;
  logic [rpfs_pkg::ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> design/rpfs_div.sv
// ----------------------------------------------------------------------------
// rpfs_div
// Restoring unsigned divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module rpfs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rpfs_pkg::QuotW-1:0]  dividend_i,
  input  logic [rpfs_pkg::StepW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [rpfs_pkg::QuotW-1:0]  quotient_o
);

  localparam logic [rpfs_pkg::DivCntW-1:0] LastCnt = rpfs_pkg::DivCntW'(rpfs_pkg::QuotW - 1);

  logic [rpfs_pkg::QuotW-1:0]   quo_q, quo_d;
  logic [rpfs_pkg::StepW-1:0]   rem_q, rem_d;
  logic [rpfs_pkg::StepW-1:0]   dvs_q;
  logic [rpfs_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q, done_q;

  logic [rpfs_pkg::StepW:0] rem_sh;
  logic [rpfs_pkg::StepW:0] rem_sub;

  // The partial remainder stays below the divisor, so it fits in StepW bits.
  always_comb begin
    rem_sh  = {rem_q, quo_q[rpfs_pkg::QuotW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    if (rem_sh >= {1'b0, dvs_q}) begin
      rem_d = rem_sub[rpfs_pkg::StepW-1:0];
      quo_d = {quo_q[rpfs_pkg::QuotW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[rpfs_pkg::StepW-1:0];
      quo_d = {quo_q[rpfs_pkg::QuotW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/rgb_palette_fade_sequencer_unit.sv
// ----------------------------------------------------------------------------
// rgb_palette_fade_sequencer_unit
// Linear color fade over a ring of palette entries, one color per idle tick.
// ----------------------------------------------------------------------------
// Each request is one update tick. A tick whose link_idle bit is clear is
// taken without leaving the idle state and changes nothing. A tick with
// link_idle set produces one color: for red, green and blue in turn the
// block computes start + (end - start) * fade_position / fade_steps between
// the current palette entry and the next one, truncating toward zero and
// saturating to 0..255. The fade counter and, at the end of a fade, the
// palette position advance as soon as the tick is taken. The three quotients
// come from a single restoring divider that retires one bit per cycle over a
// 24-bit dividend. A producing tick keeps the input not ready until its
// color is handed over: one palette read, then per channel a multiply, a
// divider start, the divide and a merge, then the hand-over of the color.
// No new producing tick is taken while one is still being computed; the
// hand-over stretches only while the output register still holds a color
// that its consumer has not taken. The finished color sits in an output
// register, so the next tick is taken while the previous color still waits
// for its consumer. Configuration writes are expected only while the block
// is idle.
// ----------------------------------------------------------------------------
module rgb_palette_fade_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rpfs_in_if.sink                       in_req_i,
  rpfs_out_if.source                    out_res_o,
  input  logic                          cfg_we_i,
  input  logic [rpfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rpfs_pkg::CfgDataW-1:0] cfg_data_i
);

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoadE = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StDivS  = 3'd3;
  localparam logic [2:0] StDivW  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  localparam logic [rpfs_pkg::PosW-1:0] PalLimit = rpfs_pkg::PosW'(rpfs_pkg::PaletteSize);

  logic [2:0] state_q, state_d;

  // Configuration registers.
  rpfs_pkg::color_t           colors_q [rpfs_pkg::NumColors];
  logic [rpfs_pkg::StepW-1:0] fade_steps_q;

  // Architectural fade state.
  logic [rpfs_pkg::PosW-1:0]  pal_pos_q;
  logic [rpfs_pkg::StepW-1:0] fade_pos_q;

  // Working registers of one computation.
  logic [rpfs_pkg::PosW-1:0]  nxt_q;
  logic [rpfs_pkg::StepW-1:0] step_q;
  logic [rpfs_pkg::StepW-1:0] div_q;
  rpfs_pkg::color_t           sc_q, ec_q;
  rpfs_pkg::chan_t            chan_q;
  logic [rpfs_pkg::QuotW-1:0] mag_q;
  logic                       neg_q;
  logic [rpfs_pkg::ChanW-1:0] red_q, green_q, blue_q;

  // Output register.
  logic                       out_valid_q;
  logic [rpfs_pkg::ChanW-1:0] out_red_q, out_green_q, out_blue_q;

  logic                       in_accept;
  logic                       start_fade;
  logic [rpfs_pkg::PosW-1:0]  cur_pos, cur_p1, nxt_pos, rd_idx;
  logic [rpfs_pkg::StepW-1:0] div_eff;
  logic [rpfs_pkg::StepW:0]   step_sum;
  rpfs_pkg::color_t           rd_color;
  logic [rpfs_pkg::ChanW-1:0] s_ch, e_ch, diff_ch, sat_ch;
  logic [rpfs_pkg::ChanW:0]   sat_sum;
  logic                       div_start, div_done;
  logic [rpfs_pkg::QuotW-1:0] quot;
  logic                       out_free;

  assign in_req_i.ready = (state_q == StIdle);
  assign in_accept      = in_req_i.valid && in_req_i.ready;
  assign start_fade     = in_accept && in_req_i.link_idle;
  assign out_free       = !out_valid_q || out_res_o.ready;

  // An out-of-range position counts as entry 0; the ring wraps after the last entry.
  always_comb begin
    cur_pos  = (pal_pos_q >= PalLimit) ? '0 : pal_pos_q;
    cur_p1   = cur_pos + 1'b1;
    nxt_pos  = (cur_p1 >= PalLimit) ? '0 : cur_p1;
    div_eff  = (fade_steps_q == '0) ? rpfs_pkg::StepW'(1) : fade_steps_q;
    step_sum = {1'b0, fade_pos_q} + 1'b1;
  end

  // A single palette read port: the start entry at accept, the end entry after.
  assign rd_idx   = (state_q == StIdle) ? cur_pos : nxt_q;
  assign rd_color = colors_q[rd_idx];

  always_comb begin
    unique case (chan_q)
      rpfs_pkg::ChRed: begin
        s_ch = sc_q[23:16];
        e_ch = ec_q[23:16];
      end
      rpfs_pkg::ChGreen: begin
        s_ch = sc_q[15:8];
        e_ch = ec_q[15:8];
      end
      default: begin
        s_ch = sc_q[7:0];
        e_ch = ec_q[7:0];
      end
    endcase
    diff_ch = (e_ch >= s_ch) ? (e_ch - s_ch) : (s_ch - e_ch);
  end

  // Apply the quotient to the start value and clamp to the channel range.
  always_comb begin
    sat_sum = {1'b0, s_ch} + {1'b0, quot[rpfs_pkg::ChanW-1:0]};
    if (neg_q) begin
      if (quot > rpfs_pkg::QuotW'(s_ch)) begin
        sat_ch = '0;
      end else begin
        sat_ch = s_ch - quot[rpfs_pkg::ChanW-1:0];
      end
    end else begin
      if (quot > rpfs_pkg::QuotW'(rpfs_pkg::ChanMax) || sat_sum[rpfs_pkg::ChanW]) begin
        sat_ch = rpfs_pkg::ChanMax;
      end else begin
        sat_ch = sat_sum[rpfs_pkg::ChanW-1:0];
      end
    end
  end

  assign div_start = (state_q == StDivS);

  rpfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_fade) state_d = StLoadE;
      StLoadE: state_d = StMul;
      StMul:   state_d = StDivS;
      StDivS:  state_d = StDivW;
      StDivW: begin
        if (div_done) begin
          state_d = (chan_q == rpfs_pkg::ChBlue) ? StDone : StMul;
        end
      end
      StDone:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      pal_pos_q    <= '0;
      fade_pos_q   <= '0;
      fade_steps_q <= rpfs_pkg::FadeStepsRst;
      colors_q     <= rpfs_pkg::ColorRst;
      chan_q       <= rpfs_pkg::ChRed;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_idx_i == rpfs_pkg::RegFadeSteps) begin
          fade_steps_q <= cfg_data_i[rpfs_pkg::StepW-1:0];
        end else begin
          colors_q[cfg_idx_i] <= cfg_data_i;
        end
      end

      // The counters move on as soon as a producing tick is taken; the
      // working registers keep the values this color is computed from.
      if (start_fade) begin
        chan_q <= rpfs_pkg::ChRed;
        if (step_sum >= {1'b0, div_eff}) begin
          fade_pos_q <= '0;
          pal_pos_q  <= nxt_pos;
        end else begin
          fade_pos_q <= step_sum[rpfs_pkg::StepW-1:0];
          pal_pos_q  <= cur_pos;
        end
      end else if (state_q == StDivW && div_done && chan_q != rpfs_pkg::ChBlue) begin
        chan_q <= chan_q + 1'b1;
      end

      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_fade) begin
      nxt_q  <= nxt_pos;
      step_q <= fade_pos_q;
      div_q  <= div_eff;
      sc_q   <= rd_color;
    end
    if (state_q == StLoadE) begin
      ec_q <= rd_color;
    end
    if (state_q == StMul) begin
      mag_q <= rpfs_pkg::QuotW'(diff_ch) * rpfs_pkg::QuotW'(step_q);
      neg_q <= (e_ch < s_ch);
    end
    if (state_q == StDivW && div_done) begin
      unique case (chan_q)
        rpfs_pkg::ChRed:   red_q   <= sat_ch;
        rpfs_pkg::ChGreen: green_q <= sat_ch;
        default:           blue_q  <= sat_ch;
      endcase
    end
    if (state_q == StDone && out_free) begin
      out_red_q   <= red_q;
      out_green_q <= green_q;
      out_blue_q  <= blue_q;
    end
  end

  assign out_res_o.valid = out_valid_q;
  assign out_res_o.red   = out_red_q;
  assign out_res_o.green = out_green_q;
  assign out_res_o.blue  = out_blue_q;

endmodule

>>> design/rpfs_chk.sv
// ----------------------------------------------------------------------------
// rpfs_chk
// Port-level checks of the palette fade sequencer, bound to its top level.
// ----------------------------------------------------------------------------
module rpfs_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_link_idle_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rpfs_pkg::ChanW-1:0] out_red_i,
  input logic [rpfs_pkg::ChanW-1:0] out_green_i,
  input logic [rpfs_pkg::ChanW-1:0] out_blue_i
);

  // A tick on a busy link is absorbed at once.
  a_busy_tick_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_link_idle_i |=> in_ready_i)
    else $error("busy-link tick did not return to ready");

  // A producing tick keeps the block not ready at the start of the color computation.
  a_idle_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_link_idle_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("block ready during color computation");

  // A new color only appears at the end of a computation.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("color produced without a computation");

  // A color held back by the consumer does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_red_i)
      && $stable(out_green_i) && $stable(out_blue_i))
    else $error("stalled color dropped or changed");

endmodule

bind rgb_palette_fade_sequencer_unit rpfs_chk u_rpfs_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_req_i.valid),
  .in_ready_i     (in_req_i.ready),
  .in_link_idle_i (in_req_i.link_idle),
  .out_valid_i    (out_res_o.valid),
  .out_ready_i    (out_res_o.ready),
  .out_red_i      (out_res_o.red),
  .out_green_i    (out_res_o.green),
  .out_blue_i     (out_res_o.blue)
);
